FILE: rtl/mac_header_byte_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// MAC header byte parser assertion macros
// Concurrent assertion shorthands, empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef MAC_HEADER_BYTE_PARSER_UNIT_DEFINES_SVH
`define MAC_HEADER_BYTE_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define MHBP_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhbp: same-cycle check failed");

`define MHBP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhbp: next-cycle check failed");

`else

`define MHBP_ASSERT_IMPLY(name, clk, rst, ante, cons)

`define MHBP_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/mhbp_pkg.sv
// ----------------------------------------------------------------------------
// MAC header byte parser package
// Field codes, field lengths and shared types of the frame parser.
// ----------------------------------------------------------------------------
package mhbp_pkg;

  localparam int MAX_FRAME_BYTES_DEFAULT = 127;

  localparam logic [3:0] EXT_ADDR_BYTES = 4'd8;
  localparam logic [3:0] KEY_LONG_BYTES = 4'd9;
  localparam logic [3:0] KEY_MID_BYTES  = 4'd5;
  localparam logic [3:0] COUNTER_BYTES  = 4'd4;

  typedef enum logic [3:0] {
    FK_FCF     = 4'd0,
    FK_SEQ     = 4'd1,
    FK_DPAN    = 4'd2,
    FK_DADDR   = 4'd3,
    FK_SPAN    = 4'd4,
    FK_SADDR   = 4'd5,
    FK_SCF     = 4'd6,
    FK_CNT     = 4'd7,
    FK_KEY     = 4'd8,
    FK_PAYLOAD = 4'd9,
    FK_FCS     = 4'd10,
    FK_EXCESS  = 4'd11
  } field_kind_t;

  typedef enum logic [1:0] {
    AM_NONE     = 2'd0,
    AM_RESERVED = 2'd1,
    AM_SHORT    = 2'd2,
    AM_EXT      = 2'd3
  } addr_mode_t;

  typedef struct packed {
    logic [15:0] control_word;
    logic [7:0]  security_control;
  } frame_ctrl_t;

  typedef struct packed {
    field_kind_t next_field;
    logic [3:0]  field_len;
  } field_step_t;

  function automatic logic [3:0] addr_len(input logic [1:0] mode);
    logic [3:0] len;
    unique case (addr_mode_t'(mode))
      AM_SHORT: len = 4'd2;
      AM_EXT:   len = EXT_ADDR_BYTES;
      default:  len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] key_len(input logic [1:0] kid);
    logic [3:0] len;
    unique case (kid)
      2'd0:    len = 4'd0;
      2'd1:    len = 4'd1;
      2'd2:    len = KEY_MID_BYTES;
      default: len = KEY_LONG_BYTES;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] field_len(input field_kind_t f, input frame_ctrl_t c);
    logic [1:0] dmode;
    logic [1:0] smode;
    logic       sec;
    logic       comp;
    logic [3:0] len;
    dmode = c.control_word[11:10];
    smode = c.control_word[15:14];
    sec   = c.control_word[3];
    comp  = c.control_word[6];
    unique case (f)
      FK_FCF:   len = 4'd2;
      FK_SEQ:   len = 4'd1;
      FK_DPAN:  len = (dmode != AM_NONE) ? 4'd2 : 4'd0;
      FK_DADDR: len = addr_len(dmode);
      FK_SPAN:  len = (smode != AM_NONE && !comp) ? 4'd2 : 4'd0;
      FK_SADDR: len = addr_len(smode);
      FK_SCF:   len = sec ? 4'd1 : 4'd0;
      FK_CNT:   len = sec ? COUNTER_BYTES : 4'd0;
      FK_KEY:   len = sec ? key_len(c.security_control[4:3]) : 4'd0;
      default:  len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/mhbp_ifs.sv
// ----------------------------------------------------------------------------
// MAC header byte parser channels
// Valid/ready channels for received bytes and labeled result items.
// ----------------------------------------------------------------------------
interface mhbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  logic [6:0] frame_length;

  modport source (output valid, rx_byte, frame_start, frame_length, input ready);
  modport sink (input valid, rx_byte, frame_start, frame_length, output ready);
endinterface

interface mhbp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [3:0]  field_byte_index;
  logic [7:0]  byte_value;
  logic [1:0]  dest_mode;
  logic [1:0]  src_mode;
  logic        security_on;
  logic [1:0]  key_id_mode;
  logic [5:0]  header_length;
  logic [6:0]  payload_length;
  logic [15:0] fcs_value;
  logic        frame_end;
  logic        length_error;

  modport source (
    output valid, field_kind, field_byte_index, byte_value, dest_mode, src_mode,
           security_on, key_id_mode, header_length, payload_length, fcs_value,
           frame_end, length_error,
    input  ready
  );
  modport sink (
    input  valid, field_kind, field_byte_index, byte_value, dest_mode, src_mode,
           security_on, key_id_mode, header_length, payload_length, fcs_value,
           frame_end, length_error,
    output ready
  );
endinterface

FILE: rtl/mhbp_field_seq.sv
// ----------------------------------------------------------------------------
// MAC header field sequencer
// Length of the current header field and the next field that is present.
// ----------------------------------------------------------------------------
module mhbp_field_seq (
  input  mhbp_pkg::field_kind_t cur_field,
  input  mhbp_pkg::frame_ctrl_t ctrl,
  output mhbp_pkg::field_step_t step
);

  logic [8:1] present;

  always_comb begin
    for (int k = 1; k <= 8; k++) begin
      present[k] = (mhbp_pkg::field_len(mhbp_pkg::field_kind_t'(4'(k)), ctrl) != 4'd0);
    end
  end

  // pick the lowest present field after the current one, else payload
  always_comb begin
    step.field_len  = mhbp_pkg::field_len(cur_field, ctrl);
    step.next_field = mhbp_pkg::FK_PAYLOAD;
    for (int k = 8; k >= 1; k--) begin
      if (4'(k) > cur_field && present[k]) begin
        step.next_field = mhbp_pkg::field_kind_t'(4'(k));
      end
    end
  end

endmodule

FILE: rtl/mac_header_byte_parser_unit.sv
// ----------------------------------------------------------------------------
// MAC header byte parser
// Labels each byte of a received 802.15.4 MAC frame with its field.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock and returns one labeled item per byte, in the
// cycle after the byte is accepted. The frame control field picks the
// optional address and security fields; each byte gets its field kind and
// index, the running header and payload lengths, the FCS on its second
// byte, and a length error when the frame is shorter than header plus FCS.
// Throughput is one byte every cycle: the field step is a single pass of
// logic between the input handshake and the result register, and input
// stalls only while the result register holds an item the sink has not
// taken. Lengths above MAX_FRAME_BYTES saturate to it.
`include "mac_header_byte_parser_unit_defines.svh"

module mac_header_byte_parser_unit #(
  parameter int MAX_FRAME_BYTES = mhbp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  mhbp_in_if.sink   in_ch,
  mhbp_out_if.source out_ch
);

  localparam logic [6:0] MAX_LEN = 7'(MAX_FRAME_BYTES);

  logic [6:0]            byte_count, byte_count_next;
  mhbp_pkg::field_kind_t current_field, current_field_next;
  logic [3:0]            index_in_field, index_in_field_next;
  mhbp_pkg::frame_ctrl_t ctrl, ctrl_next;
  logic [6:0]            length_latched, length_latched_next;
  logic [5:0]            header_count, header_count_next;
  logic [7:0]            fcs_high, fcs_high_next;

  logic                  out_valid;
  logic                  in_acc;

  mhbp_pkg::field_kind_t cf;
  mhbp_pkg::frame_ctrl_t ctrl_base;
  mhbp_pkg::field_step_t step;
  logic [6:0]            pos, len, len_sat;
  logic [3:0]            idx, idx_inc, fcs_idx;
  logic [5:0]            hc;
  logic [7:0]            fh, b, hc2, pos2;

  mhbp_pkg::field_kind_t kind_next;
  logic [3:0]            out_idx_next;
  logic [15:0]           fcs_next;
  logic [6:0]            payload_next;
  logic                  err_next, end_next;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  assign len_sat = (in_ch.frame_length > MAX_LEN) ? MAX_LEN : in_ch.frame_length;

  always_comb begin
    if (in_ch.frame_start) begin
      pos       = '0;
      cf        = mhbp_pkg::FK_FCF;
      idx       = '0;
      ctrl_base = '0;
      len       = len_sat;
      hc        = '0;
      fh        = '0;
    end else begin
      pos       = byte_count;
      cf        = current_field;
      idx       = index_in_field;
      ctrl_base = ctrl;
      len       = length_latched;
      hc        = header_count;
      fh        = fcs_high;
    end
  end

  // capture header control bytes before the field step sees them
  always_comb begin
    ctrl_next = ctrl_base;
    if (pos < len && cf < mhbp_pkg::FK_PAYLOAD) begin
      if (cf == mhbp_pkg::FK_FCF) begin
        if (idx == 4'd0) begin
          ctrl_next.control_word[7:0] = b;
        end else begin
          ctrl_next.control_word[15:8] = b;
        end
      end else if (cf == mhbp_pkg::FK_SCF) begin
        ctrl_next.security_control = b;
      end
    end
  end

  mhbp_field_seq u_field_seq (
    .cur_field (cf),
    .ctrl      (ctrl_next),
    .step      (step)
  );

  assign idx_inc = idx + 4'd1;
  assign pos2    = {1'b0, pos} + 8'd2;
  assign fcs_idx = 4'(pos2 - {1'b0, len});

  always_comb begin
    current_field_next  = cf;
    index_in_field_next = idx;
    header_count_next   = hc;
    fcs_high_next       = fh;
    length_latched_next = len;
    byte_count_next     = (pos < MAX_LEN) ? pos + 7'd1 : MAX_LEN;
    kind_next           = mhbp_pkg::FK_EXCESS;
    out_idx_next        = '0;
    fcs_next            = '0;
    priority if (pos >= len) begin
      kind_next = mhbp_pkg::FK_EXCESS;
    end else if (cf < mhbp_pkg::FK_PAYLOAD) begin
      kind_next         = cf;
      out_idx_next      = idx;
      header_count_next = hc + 6'd1;
      if (idx_inc >= step.field_len) begin
        current_field_next  = step.next_field;
        index_in_field_next = '0;
      end else begin
        index_in_field_next = idx_inc;
      end
    end else if (pos2 >= {1'b0, len}) begin
      kind_next    = mhbp_pkg::FK_FCS;
      out_idx_next = fcs_idx;
      if (fcs_idx == 4'd0) begin
        fcs_high_next = b;
      end else begin
        fcs_next = {fh, b};
      end
    end else begin
      kind_next = mhbp_pkg::FK_PAYLOAD;
    end
  end

  assign hc2          = {2'b0, header_count_next} + 8'd2;
  assign err_next     = hc2 > {1'b0, len};
  assign payload_next = err_next ? '0 : 7'({1'b0, len} - hc2);
  assign end_next     = (len != 7'd0) && (pos == len - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      current_field  <= mhbp_pkg::FK_FCF;
      index_in_field <= '0;
      ctrl           <= '0;
      length_latched <= '0;
      header_count   <= '0;
      fcs_high       <= '0;
    end else if (in_acc) begin
      byte_count     <= byte_count_next;
      current_field  <= current_field_next;
      index_in_field <= index_in_field_next;
      ctrl           <= ctrl_next;
      length_latched <= length_latched_next;
      header_count   <= header_count_next;
      fcs_high       <= fcs_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_ch.field_kind       <= kind_next;
      out_ch.field_byte_index <= out_idx_next;
      out_ch.byte_value       <= b;
      out_ch.dest_mode        <= ctrl_next.control_word[11:10];
      out_ch.src_mode         <= ctrl_next.control_word[15:14];
      out_ch.security_on      <= ctrl_next.control_word[3];
      out_ch.key_id_mode      <= ctrl_next.security_control[4:3];
      out_ch.header_length    <= header_count_next;
      out_ch.payload_length   <= payload_next;
      out_ch.fcs_value        <= fcs_next;
      out_ch.frame_end        <= end_next;
      out_ch.length_error     <= err_next;
    end
  end

  assign out_ch.valid = out_valid;

  `MHBP_ASSERT_NEXT(a_acc_gives_item, clk, rst, in_acc, out_valid)
  `MHBP_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, byte_count <= MAX_LEN)
  `MHBP_ASSERT_IMPLY(a_index_bound, clk, rst, 1'b1, index_in_field <= 4'd8)
  `MHBP_ASSERT_IMPLY(a_fcs_index, clk, rst,
    out_valid && out_ch.field_kind == mhbp_pkg::FK_FCS, out_ch.field_byte_index <= 4'd1)
  `MHBP_ASSERT_IMPLY(a_length_sum, clk, rst, out_valid && !out_ch.length_error,
    {2'b0, out_ch.header_length} + {1'b0, out_ch.payload_length} + 8'd2 == {1'b0, length_latched})

endmodule

FILE: tb/mac_header_byte_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC header byte parser testbench
// Sends 802.15.4 frames byte by byte, some well formed, some short, cut off or
// padded with bytes past their end. A model of the field walk predicts every
// labeled item, and each item is checked field by field in arrival order.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module mac_header_byte_parser_unit_tb;

  localparam int MAX_BYTES    = mhbp_pkg::MAX_FRAME_BYTES_DEFAULT;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [1:0] KID_IMPLICIT = 2'd0;
  localparam logic [1:0] KID_INDEX    = 2'd1;
  localparam logic [1:0] KID_SRC4     = 2'd2;

  typedef struct {
    logic [7:0] value;
    logic       start;
    logic [6:0] flen;
    bit         drain;
  } rx_item_t;

  typedef struct packed {
    mhbp_pkg::field_kind_t kind;
    logic [3:0]  idx;
    logic [7:0]  value;
    logic [1:0]  dmode;
    logic [1:0]  smode;
    logic        sec;
    logic [1:0]  kid;
    logic [5:0]  hdr_len;
    logic [6:0]  pay_len;
    logic [15:0] fcs;
    logic        frame_last;
    logic        len_err;
  } label_t;

  logic clk = 1'b0;
  logic rst;

  mhbp_in_if  byte_ch ();
  mhbp_out_if label_ch ();

  mac_header_byte_parser_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (byte_ch),
    .out_ch (label_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_item_t pending_bytes[$];
  label_t   expected_labels[$];

  logic [6:0]  rx_pos;
  mhbp_pkg::field_kind_t cur_kind;
  logic [3:0]  cur_idx;
  logic [15:0] ctl_word;
  logic [7:0]  sec_ctl;
  logic [6:0]  flen_lat;
  logic [5:0]  hdr_seen;
  logic [7:0]  fcs_hi;

  logic byte_taken;
  logic label_taken;
  int   src_idle;
  int   sink_wait;
  bit   src_calm;
  bit   sink_calm;
  int   cycle_cnt;
  int   mismatches;
  int   labels_checked;
  int   bytes_taken;
  int   frames_built;
  int   err_labels;

  function automatic int fld_len(mhbp_pkg::field_kind_t k, logic [15:0] cw,
                                 logic [7:0] scf);
    logic [1:0] dm;
    logic [1:0] sm;
    logic       sec;
    logic       comp;
    int         n;
    dm   = cw[11:10];
    sm   = cw[15:14];
    sec  = cw[3];
    comp = cw[6];
    case (k)
      mhbp_pkg::FK_FCF:   n = 2;
      mhbp_pkg::FK_SEQ:   n = 1;
      mhbp_pkg::FK_DPAN:  n = (dm != mhbp_pkg::AM_NONE) ? 2 : 0;
      mhbp_pkg::FK_DADDR: n = (dm == mhbp_pkg::AM_SHORT) ? 2 :
                              (dm == mhbp_pkg::AM_EXT) ? int'(mhbp_pkg::EXT_ADDR_BYTES) : 0;
      mhbp_pkg::FK_SPAN:  n = (sm != mhbp_pkg::AM_NONE && !comp) ? 2 : 0;
      mhbp_pkg::FK_SADDR: n = (sm == mhbp_pkg::AM_SHORT) ? 2 :
                              (sm == mhbp_pkg::AM_EXT) ? int'(mhbp_pkg::EXT_ADDR_BYTES) : 0;
      mhbp_pkg::FK_SCF:   n = sec ? 1 : 0;
      mhbp_pkg::FK_CNT:   n = sec ? int'(mhbp_pkg::COUNTER_BYTES) : 0;
      mhbp_pkg::FK_KEY: begin
        if (!sec) n = 0;
        else if (scf[4:3] == KID_IMPLICIT) n = 0;
        else if (scf[4:3] == KID_INDEX) n = 1;
        else if (scf[4:3] == KID_SRC4) n = int'(mhbp_pkg::KEY_MID_BYTES);
        else n = int'(mhbp_pkg::KEY_LONG_BYTES);
      end
      default:  n = 0;
    endcase
    return n;
  endfunction

  function automatic label_t label_byte(logic [7:0] b, logic start, logic [6:0] flen);
    label_t r;
    int     pos;
    int     len;
    int     nk;
    int     left;
    if (start) begin
      rx_pos   = '0;
      cur_kind = mhbp_pkg::FK_FCF;
      cur_idx  = '0;
      ctl_word = '0;
      sec_ctl  = '0;
      hdr_seen = '0;
      fcs_hi   = '0;
      flen_lat = (int'(flen) > MAX_BYTES) ? 7'(MAX_BYTES) : flen;
    end
    pos = int'(rx_pos);
    len = int'(flen_lat);
    r = '0;
    r.value = b;
    if (pos >= len) begin
      r.kind = mhbp_pkg::FK_EXCESS;
    end else if (cur_kind < mhbp_pkg::FK_PAYLOAD) begin
      r.kind = cur_kind;
      r.idx  = cur_idx;
      if (cur_kind == mhbp_pkg::FK_FCF) begin
        if (cur_idx == 4'd0) ctl_word[7:0] = b;
        else ctl_word[15:8] = b;
      end else if (cur_kind == mhbp_pkg::FK_SCF) begin
        sec_ctl = b;
      end
      hdr_seen = hdr_seen + 6'd1;
      cur_idx  = cur_idx + 4'd1;
      if (int'(cur_idx) >= fld_len(cur_kind, ctl_word, sec_ctl)) begin
        nk = int'(cur_kind) + 1;
        while (nk < int'(mhbp_pkg::FK_PAYLOAD) &&
               fld_len(mhbp_pkg::field_kind_t'(nk), ctl_word, sec_ctl) == 0)
          nk++;
        cur_kind = mhbp_pkg::field_kind_t'(nk);
        cur_idx  = '0;
      end
    end else if (pos + 2 >= len) begin
      r.kind = mhbp_pkg::FK_FCS;
      r.idx  = 4'(pos + 2 - len);
      if (pos + 2 == len) fcs_hi = b;
      else r.fcs = {fcs_hi, b};
    end else begin
      r.kind = mhbp_pkg::FK_PAYLOAD;
    end
    r.frame_last = (len != 0 && pos == len - 1);
    rx_pos       = (pos < MAX_BYTES) ? 7'(pos + 1) : 7'(MAX_BYTES);
    left         = len - int'(hdr_seen) - 2;
    r.pay_len    = (left > 0) ? 7'(left) : 7'd0;
    r.len_err    = (int'(hdr_seen) + 2 > len);
    r.dmode      = ctl_word[11:10];
    r.smode      = ctl_word[15:14];
    r.sec        = ctl_word[3];
    r.kid        = sec_ctl[4:3];
    r.hdr_len    = hdr_seen;
    return r;
  endfunction

  task automatic add_item(input logic [7:0] b, input logic start, input logic [6:0] flen,
                          input bit drain);
    rx_item_t it;
    it.value = b;
    it.start = start;
    it.flen  = flen;
    it.drain = drain;
    pending_bytes.push_back(it);
  endtask

  task automatic add_frame(input logic [15:0] cw, input logic [7:0] scf, input int len,
                           input int nbytes, input bit drain);
    int         scf_at;
    logic [7:0] b;
    scf_at = 0;
    for (int k = int'(mhbp_pkg::FK_FCF); k <= int'(mhbp_pkg::FK_SADDR); k++)
      scf_at += fld_len(mhbp_pkg::field_kind_t'(k), cw, scf);
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 0) b = cw[7:0];
      else if (i == 1) b = cw[15:8];
      else if (cw[3] && i == scf_at) b = scf;
      add_item(b, i == 0, (i == 0) ? 7'(len) : 7'($urandom_range(0, 127)), drain && i == 0);
    end
    frames_built++;
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h (item %0d)",
                                name, got, want, labels_checked));
  endtask

  // sender: hold until taken, then idle or present the next item
  always @(negedge clk) begin : drv
    rx_item_t it;
    if (!rst && (!byte_ch.valid || byte_taken)) begin
      if (src_idle > 0) begin
        byte_ch.valid <= 1'b0;
        src_idle--;
      end else if (pending_bytes.size() == 0 ||
                   (pending_bytes[0].drain && expected_labels.size() != 0)) begin
        byte_ch.valid <= 1'b0;
      end else begin
        it = pending_bytes.pop_front();
        byte_ch.valid        <= 1'b1;
        byte_ch.rx_byte      <= it.value;
        byte_ch.frame_start  <= it.start;
        byte_ch.frame_length <= it.flen;
        if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
        src_idle = src_calm ? 0 : $urandom_range(0, 5);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (label_taken) begin
        if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
        sink_wait = sink_calm ? 0 : $urandom_range(0, 5);
      end
      label_ch.ready <= (sink_wait == 0);
      if (sink_wait > 0 && label_ch.valid) sink_wait--;
    end
  end

  always @(posedge clk) begin : mon
    label_t want;
    if (rst) begin
      byte_taken  <= 1'b0;
      label_taken <= 1'b0;
    end else begin
      byte_taken  <= byte_ch.valid && byte_ch.ready;
      label_taken <= label_ch.valid && label_ch.ready;
      if (byte_ch.valid && byte_ch.ready) begin
        expected_labels.push_back(label_byte(byte_ch.rx_byte, byte_ch.frame_start,
                                             byte_ch.frame_length));
        bytes_taken++;
      end
      if (label_ch.valid && label_ch.ready) begin
        if (expected_labels.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_labels.pop_front();
          check_field("field_kind", 16'(label_ch.field_kind), 16'(want.kind));
          check_field("field_byte_index", 16'(label_ch.field_byte_index), 16'(want.idx));
          check_field("byte_value", 16'(label_ch.byte_value), 16'(want.value));
          check_field("dest_mode", 16'(label_ch.dest_mode), 16'(want.dmode));
          check_field("src_mode", 16'(label_ch.src_mode), 16'(want.smode));
          check_field("security_on", 16'(label_ch.security_on), 16'(want.sec));
          check_field("key_id_mode", 16'(label_ch.key_id_mode), 16'(want.kid));
          check_field("header_length", 16'(label_ch.header_length), 16'(want.hdr_len));
          check_field("payload_length", 16'(label_ch.payload_length), 16'(want.pay_len));
          check_field("fcs_value", label_ch.fcs_value, want.fcs);
          check_field("frame_end", 16'(label_ch.frame_end), 16'(want.frame_last));
          check_field("length_error", 16'(label_ch.length_error), 16'(want.len_err));
          if (want.len_err) err_labels++;
          labels_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected",
               cycle_cnt, expected_labels.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : main
    logic [15:0] cw;
    logic [7:0]  scf;
    int          hdr;
    int          len;
    int          nbytes;
    int          pick;
    int          nframe;
    int          random_items;
    rst                  = 1'b1;
    byte_ch.valid        = 1'b0;
    byte_ch.rx_byte      = 8'h00;
    byte_ch.frame_start  = 1'b0;
    byte_ch.frame_length = 7'd0;
    label_ch.ready       = 1'b0;
    src_idle             = 0;
    sink_wait            = 0;
    src_calm             = 1'b0;
    sink_calm            = 1'b0;
    cycle_cnt            = 0;
    mismatches           = 0;
    labels_checked       = 0;
    bytes_taken          = 0;
    frames_built         = 0;
    err_labels           = 0;
    rx_pos               = '0;
    cur_kind             = mhbp_pkg::FK_FCF;
    cur_idx              = '0;
    ctl_word             = '0;
    sec_ctl              = '0;
    flen_lat             = '0;
    hdr_seen             = '0;
    fcs_hi               = '0;

    // bytes before any frame start
    add_item(8'h00, 1'b0, 7'd127, 1'b0);
    add_item(8'hFF, 1'b0, 7'd0, 1'b0);
    // empty frame, one byte frame, frame ending inside the header
    add_frame(16'h0000, 8'h00, 0, 1, 1'b0);
    add_frame(16'h0000, 8'h00, 1, 1, 1'b0);
    add_frame(16'h4400, 8'h00, 3, 3, 1'b0);
    // no addresses: control, sequence, FCS
    add_frame(16'h0000, 8'h00, 5, 5, 1'b0);
    // reserved modes on both sides, one payload byte, two bytes past the end
    add_frame(16'h4400, 8'h00, 10, 12, 1'b0);

    nframe       = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      cw  = 16'($urandom_range(0, 65535));
      scf = 8'($urandom_range(0, 255));
      hdr = 0;
      for (int k = int'(mhbp_pkg::FK_FCF); k <= int'(mhbp_pkg::FK_KEY); k++)
        hdr += fld_len(mhbp_pkg::field_kind_t'(k), cw, scf);
      pick = $urandom_range(0, 99);
      if (nframe == 0) begin
        // longest frame, then run the byte counter into saturation
        len    = MAX_BYTES;
        nbytes = MAX_BYTES + 4;
      end else if (pick < 75) begin
        len = hdr + 2 + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 125 - hdr)
                                                      : $urandom_range(0, 12));
        nbytes = len + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
      end else if (pick < 88) begin
        len    = $urandom_range(0, hdr + 3);
        nbytes = len + $urandom_range(0, 2);
      end else begin
        len    = $urandom_range(0, 127);
        nbytes = $urandom_range(1, len + 3);
      end
      if (nbytes < 1) nbytes = 1;
      add_frame(cw, scf, len, nbytes, (nframe % 12) == 0);
      random_items += nbytes;
      nframe++;
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || byte_ch.valid) @(posedge clk);
    while (expected_labels.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d frames as %0d bytes; %0d labeled items compared.",
             frames_built, bytes_taken, labels_checked);
    $display("%0d items flagged a short frame; %0d mismatches found.", err_labels, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
